/* hdl/rgab_pkg.sv */
// Shared types and constants for the run-length glyph alpha blender.
`default_nettype none

package rgab_pkg;

	// Absolute surface coordinates are 13 bits wide
	localparam int ABS_BITS = 13;

	// Configuration port geometry
	localparam int CFG_DATA_BITS = 32;
	localparam int CFG_ADDR_BITS = 5;
	localparam int CFG_IDX_BITS  = 3;

	// Configuration register indexes (byte address is 4 * index)
	localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_X       = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_Y       = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_SURFACE_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_SURFACE_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_INK_COLOR      = 3'd4;

	// Code byte values with a special meaning
	localparam logic [7:0] ESCAPE_CODE = 8'h00;
	localparam logic [7:0] END_CODE    = 8'hFF;

	// Input request: one code byte and the pixel under the cursor
	typedef struct packed {
		logic [7:0]  code_byte;
		logic [31:0] background_pixel;
	} code_item_t;

	// Result request: optional pixel write plus cursor after the step
	typedef struct packed {
		logic                write_enable;
		logic [ABS_BITS-1:0] write_x;
		logic [ABS_BITS-1:0] write_y;
		logic [31:0]         blended_pixel;
		logic [ABS_BITS-1:0] next_x;
		logic [ABS_BITS-1:0] next_y;
		logic                glyph_done;
	} pixel_item_t;

endpackage

`default_nettype wire

/* hdl/rgab_if.sv */
// Valid/ready channel interfaces for code bytes and pixel results.
`default_nettype none

interface rgab_code_if;
	logic                    valid;
	logic                    ready;
	rgab_pkg::code_item_t    data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rgab_pixel_if;
	logic                    valid;
	logic                    ready;
	rgab_pkg::pixel_item_t   data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/rle_glyph_alpha_blend.sv */
// Run-length alpha-mask glyph blender: parser, cursor and per-byte pixel blend.
//
//   channel   dir   handshake       payload
//   codes     in    valid/ready     code_byte, background_pixel
//   writes    out   valid/ready     write_enable, write_x/y, blended_pixel,
//                                   next_x/y, glyph_done
//   apb       in    psel/penable    origin, surface size, ink color
//
// One code byte per cycle sustained while writes.ready is high; a result passes through
// the input register, then the result register. The parser/cursor update is a loop on
// the mode and offset registers, which sets the rate.
// Reset clears parse state, offsets, configuration and both valid flags.
// codes.ready drops only while both the input and result registers are full
// and writes.ready is low.
`default_nettype none

module rle_glyph_alpha_blend #(
	parameter int GLYPH_WIDTH  = 6,
	parameter int GLYPH_HEIGHT = 11,
	parameter int COORD_BITS   = 12
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [rgab_pkg::CFG_ADDR_BITS-1:0] paddr,
	input  wire logic [rgab_pkg::CFG_DATA_BITS-1:0] pwdata,
	output logic      [rgab_pkg::CFG_DATA_BITS-1:0] prdata,
	output logic                                    pready,
	rgab_code_if.sink                               codes,
	rgab_pixel_if.source                            writes
);

	localparam int ABS_W  = rgab_pkg::ABS_BITS;
	localparam int SUM_W  = (COORD_BITS > ABS_W) ? COORD_BITS : ABS_W;
	localparam int BOX_W  = ABS_W + 1;

	typedef enum logic [2:0] {
		MODE_NORMAL,
		MODE_ESC,
		MODE_PEND_ROW,
		MODE_PEND_ROW_ZERO,
		MODE_DONE
	} mode_t;

	// Configuration registers
	logic [11:0] origin_x_q;
	logic [11:0] origin_y_q;
	logic [12:0] surface_width_q;
	logic [12:0] surface_height_q;
	logic [31:0] ink_color_q;

	// Input register
	rgab_pkg::code_item_t item_s1;
	logic                 valid_s1;

	// Parse state and result register
	mode_t                 mode_q;
	logic [COORD_BITS-1:0] col_off_q;
	logic [COORD_BITS-1:0] row_off_q;
	rgab_pkg::pixel_item_t out_q;
	logic                  out_valid_q;

	// Combinational next values
	mode_t                 mode_d;
	logic [COORD_BITS-1:0] col_d;
	logic [COORD_BITS-1:0] row_d;
	logic [COORD_BITS-1:0] col_wr;
	logic                  do_alpha;
	logic                  done_d;
	logic                  box_ok;
	logic [31:0]           blended;
	rgab_pkg::pixel_item_t result_d;

	logic [rgab_pkg::CFG_IDX_BITS-1:0] cfg_idx;
	logic                              cfg_write;
	logic                              adv_s1;
	logic                              take_in;

	// APB write/read decode
	assign pready    = 1'b1;
	assign cfg_idx   = paddr[rgab_pkg::CFG_ADDR_BITS-1:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		case (cfg_idx)
			rgab_pkg::REG_ORIGIN_X:       prdata = 32'(origin_x_q);
			rgab_pkg::REG_ORIGIN_Y:       prdata = 32'(origin_y_q);
			rgab_pkg::REG_SURFACE_WIDTH:  prdata = 32'(surface_width_q);
			rgab_pkg::REG_SURFACE_HEIGHT: prdata = 32'(surface_height_q);
			rgab_pkg::REG_INK_COLOR:      prdata = ink_color_q;
			default:                      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q       <= '0;
			origin_y_q       <= '0;
			surface_width_q  <= '0;
			surface_height_q <= '0;
			ink_color_q      <= '0;
		end else if (cfg_write) begin
			case (cfg_idx)
				rgab_pkg::REG_ORIGIN_X:       origin_x_q       <= pwdata[11:0];
				rgab_pkg::REG_ORIGIN_Y:       origin_y_q       <= pwdata[11:0];
				rgab_pkg::REG_SURFACE_WIDTH:  surface_width_q  <= pwdata[12:0];
				rgab_pkg::REG_SURFACE_HEIGHT: surface_height_q <= pwdata[12:0];
				rgab_pkg::REG_INK_COLOR:      ink_color_q      <= pwdata;
				default: ;
			endcase
		end
	end

	// Flow control: stage 1 advances when the result register is free or drains
	assign adv_s1       = valid_s1 && (!out_valid_q || writes.ready);
	assign codes.ready  = !valid_s1 || adv_s1;
	assign take_in      = codes.valid && codes.ready;
	assign writes.valid = out_valid_q;
	assign writes.data  = out_q;

	// Capture the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			item_s1  <= '0;
		end else begin
			if (take_in) begin
				item_s1 <= codes.data;
			end
			valid_s1 <= take_in || (valid_s1 && !adv_s1);
		end
	end

	// Glyph box must lie inside the surface for any write
	assign box_ok = (BOX_W'(origin_x_q) + BOX_W'(GLYPH_WIDTH) <= BOX_W'(surface_width_q)) &&
		(BOX_W'(origin_y_q) + BOX_W'(GLYPH_HEIGHT) <= BOX_W'(surface_height_q));

	// Parse the code byte and move the cursor
	always_comb begin
		logic [COORD_BITS-1:0] col0;
		logic [COORD_BITS-1:0] row0;
		logic [COORD_BITS-1:0] code_ext;
		mode_t                 mode0;
		logic [7:0]            code;

		code     = item_s1.code_byte;
		code_ext = COORD_BITS'(code);
		// a finished glyph restarts at the origin
		if (mode_q == MODE_DONE) begin
			col0  = '0;
			row0  = '0;
			mode0 = MODE_NORMAL;
		end else begin
			col0  = col_off_q;
			row0  = row_off_q;
			mode0 = mode_q;
		end
		col_wr   = col0;
		row_d    = row0;
		mode_d   = mode0;
		do_alpha = 1'b0;
		done_d   = 1'b0;
		case (mode0)
			MODE_ESC: begin
				if (code != rgab_pkg::ESCAPE_CODE) begin
					col_wr = col0 + code_ext;
					mode_d = MODE_NORMAL;
				end else begin
					mode_d = MODE_PEND_ROW;
				end
			end
			MODE_PEND_ROW: begin
				if (code != rgab_pkg::ESCAPE_CODE) begin
					row_d    = row0 + COORD_BITS'(1);
					col_wr   = '0;
					do_alpha = 1'b1;
					mode_d   = MODE_NORMAL;
				end else begin
					mode_d = MODE_PEND_ROW_ZERO;
				end
			end
			MODE_PEND_ROW_ZERO: begin
				if (code == rgab_pkg::END_CODE) begin
					done_d = 1'b1;
					mode_d = MODE_DONE;
				end else begin
					// commit the held-back row, then treat as skip or new row
					row_d  = row0 + COORD_BITS'(1);
					col_wr = code_ext;
					if (code != rgab_pkg::ESCAPE_CODE) begin
						mode_d = MODE_NORMAL;
					end else begin
						mode_d = MODE_PEND_ROW;
					end
				end
			end
			default: begin
				if (code != rgab_pkg::ESCAPE_CODE) begin
					do_alpha = 1'b1;
				end else begin
					mode_d = MODE_ESC;
				end
			end
		endcase
		col_d = do_alpha ? col_wr + COORD_BITS'(1) : col_wr;
	end

	// Blend each byte toward the ink color
	always_comb begin
		logic [8:0]  alpha;
		logic [15:0] diff;
		logic [15:0] prod;

		alpha = {1'b0, item_s1.code_byte} + 9'(item_s1.code_byte[7]);
		for (int i = 0; i < 4; i++) begin
			diff = {8'h00, ink_color_q[8*i +: 8]} - {8'h00, item_s1.background_pixel[8*i +: 8]};
			prod = 16'(alpha * diff);
			blended[8*i +: 8] = item_s1.background_pixel[8*i +: 8] + prod[15:8];
		end
	end

	// Assemble the result
	always_comb begin
		logic [SUM_W-1:0] wx_sum;
		logic [SUM_W-1:0] wy_sum;
		logic [SUM_W-1:0] nx_sum;
		logic [SUM_W-1:0] ny_sum;

		wx_sum = SUM_W'(origin_x_q) + SUM_W'(col_wr);
		wy_sum = SUM_W'(origin_y_q) + SUM_W'(row_d);
		nx_sum = SUM_W'(origin_x_q) + SUM_W'(col_d);
		ny_sum = SUM_W'(origin_y_q) + SUM_W'(row_d);

		result_d = '0;
		if (do_alpha && box_ok) begin
			result_d.write_enable  = 1'b1;
			result_d.write_x       = wx_sum[ABS_W-1:0];
			result_d.write_y       = wy_sum[ABS_W-1:0];
			result_d.blended_pixel = blended;
		end
		result_d.next_x     = nx_sum[ABS_W-1:0];
		result_d.next_y     = ny_sum[ABS_W-1:0];
		result_d.glyph_done = done_d;
	end

	// Hold parse state and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_NORMAL;
			col_off_q   <= '0;
			row_off_q   <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (adv_s1) begin
				mode_q      <= mode_d;
				col_off_q   <= col_d;
				row_off_q   <= row_d;
				out_q       <= result_d;
				out_valid_q <= 1'b1;
			end else if (writes.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A delivered write implies the glyph box lies inside the surface
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.write_enable) |-> box_ok)
		else $error("write issued while glyph box is outside the surface");

	// An end marker completes the glyph in the next result
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && mode_q == MODE_PEND_ROW_ZERO && item_s1.code_byte == rgab_pkg::END_CODE)
		|=> (mode_q == MODE_DONE && out_valid_q && out_q.glyph_done && !out_q.write_enable))
		else $error("end marker did not finish the glyph");

	// Requests stall only when both registers are full and the sink is stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		!codes.ready |-> (valid_s1 && out_valid_q && !writes.ready))
		else $error("input stalled without back pressure");

endmodule

`default_nettype wire
